// ===== src/rotation_matrix_to_euler_zxz_defines.svh =====
// Assertion macros for the files that assert.
`ifndef ROTATION_MATRIX_TO_EULER_ZXZ_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ZXZ_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define RMEZ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define RMEZ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/rmez_pkg.sv =====
`default_nettype none
package rmez_pkg;
   localparam int ELEMENT_FRAC_BITS = 14;
   localparam int ANGLE_BITS = 16;
   localparam int ELEM_W = 16;
   localparam int THR_W = 29;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(268435);
   localparam int GUARD_BITS = 16;
   localparam int CORDIC_STEPS = 32;
   localparam int CORDIC_W = 36;
   localparam int RAD_W = 29;
   localparam int SQRT_STEPS = 15;
   localparam int SQRT_W = 30;
   localparam int LANE_LAT = 1 + 1 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;
   localparam int ANGLE_SH = 32 - ANGLE_BITS;
   localparam logic [32:0] ROUND_ADD = (ANGLE_SH > 0) ? 33'(64'd1 << (ANGLE_SH - 1)) : 33'd0;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = CORDIC_W'(64'h4000_0000);
   localparam logic signed [31:0] ONE_SQ = 32'sd1 <<< (2 * ELEMENT_FRAC_BITS);

   typedef struct packed {
      logic dpos;
      logic big;
      logic npos;
   } rmez_flags_type;

   typedef struct packed {
      logic vld;
      logic gimbal;
      logic mir_a;
      logic mir_g;
   } rmez_side_type;

   function automatic logic [31:0] atan_entry(input int i);
      logic [31:0] r;
      unique case (i)
         0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
         3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
         6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
         9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
        12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
        15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
        18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
        21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
        24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
        27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
        30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== src/rmez_if.sv =====
`default_nettype none
interface rmez_req_if;
   import rmez_pkg::*;
   logic valid;
   logic ready;
   logic signed [ELEM_W-1:0] m00;
   logic signed [ELEM_W-1:0] m02;
   logic signed [ELEM_W-1:0] m10;
   logic signed [ELEM_W-1:0] m12;
   logic signed [ELEM_W-1:0] m20;
   logic signed [ELEM_W-1:0] m21;
   logic signed [ELEM_W-1:0] m22;
   modport source(output valid, m00, m02, m10, m12, m20, m21, m22, input ready);
   modport sink(input valid, m00, m02, m10, m12, m20, m21, m22, output ready);
endinterface

interface rmez_rsp_if;
   import rmez_pkg::*;
   logic valid;
   logic ready;
   logic [ANGLE_BITS-1:0] alpha_angle;
   logic [ANGLE_BITS-1:0] beta_angle;
   logic [ANGLE_BITS-1:0] gamma_angle;
   logic gimbal_case;
   modport source(output valid, alpha_angle, beta_angle, gamma_angle, gimbal_case,
                  input ready);
   modport sink(input valid, alpha_angle, beta_angle, gamma_angle, gimbal_case,
                output ready);
endinterface
`default_nettype wire

// ===== src/rotation_matrix_to_euler_zxz.sv =====
// A request transaction passes, once accepted, through the input register,
// the operand register, 51 registers in each angle lane (square, radicand,
// 15 square-root digits, CORDIC setup, 32 CORDIC rotations, rounding) and
// the output register before it becomes a response.
// Throughput: one transaction per cycle, since each stage does one step of work
// and the whole pipeline advances together. It holds only while the output register is empty or its response is taken.
// Reset (synchronous, active high) clears all valid bits and loads the
// gimbal threshold with its default; datapath registers are not reset.
`default_nettype none
`include "rotation_matrix_to_euler_zxz_defines.svh"
module rotation_matrix_to_euler_zxz import rmez_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   rmez_req_if.sink         req,
   rmez_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   // The configuration space holds a single register, so every word
   // address in the two-bit space decodes to the gimbal threshold.
   logic [THR_W-1:0] thr_ff;
   logic [THR_W-1:0] thr_in;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == csr_paddr[1:0];
   assign csr_prdata = 32'(thr_ff);
   assign thr_in     = csr_wr ? csr_pwdata[THR_W-1:0] : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // The pipeline moves as one unit. It advances whenever the output
   // register is empty or is being emptied, so a new transaction enters
   // in the same cycle that a waiting response is taken.
   logic en;
   logic rsp_vld_ff;

   assign en        = !rsp_vld_ff || rsp.ready;
   assign req.ready = en;

   // Stage 1: register the elements and square m22.
   logic                     vld1_ff;
   logic signed [ELEM_W-1:0] m00_ff, m02_ff, m10_ff, m12_ff, m20_ff, m21_ff, m22_ff;
   logic [30:0]              m22sq_ff;
   logic [31:0]              m22sq_full;

   assign m22sq_full = 32'(req.m22 * req.m22);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m00_ff   <= req.m00;
         m02_ff   <= req.m02;
         m10_ff   <= req.m10;
         m12_ff   <= req.m12;
         m20_ff   <= req.m20;
         m21_ff   <= req.m21;
         m22sq_ff <= m22sq_full[30:0];
         m22_ff   <= req.m22;
      end
   end

   // Stage 2: D = 1 - m22^2, the gimbal test and the operand choice of
   // each lane. Lane A produces alpha, from m00 over one in the gimbal case
   // and from m21 over sqrt(D) otherwise. Lane B gives beta, lane C gamma.
   logic signed [31:0]     d_val;
   logic [31:0]            d_mag;
   logic                   gimbal;
   logic signed [ELEM_W:0] na_ff, nb_ff, nc_ff;
   logic signed [31:0]     da_ff, db_ff, dc_ff;
   rmez_side_type          side_in;
   rmez_side_type          side_ff [0:LANE_LAT];

   always_comb begin
      d_val        = ONE_SQ - $signed({1'b0, m22sq_ff});
      d_mag        = d_val < 0 ? 32'(-d_val) : 32'(d_val);
      gimbal       = d_mag < 32'(thr_ff);
      side_in.vld    = vld1_ff;
      side_in.gimbal = gimbal;
      side_in.mir_a  = gimbal ? m10_ff < 0 : m20_ff < 0;
      side_in.mir_g  = m02_ff < 0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         na_ff <= gimbal ? (ELEM_W+1)'(m00_ff) : (ELEM_W+1)'(m21_ff);
         da_ff <= gimbal ? ONE_SQ : d_val;
         nb_ff <= (ELEM_W+1)'(m22_ff);
         db_ff <= ONE_SQ;
         nc_ff <= -((ELEM_W+1)'(m12_ff));
         dc_ff <= d_val;
      end
   end

   // The branch decision and mirror signs travel beside the lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LANE_LAT; k++) begin
            side_ff[k] <= '0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k <= LANE_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   logic [ANGLE_BITS-1:0] ang_a, ang_b, ang_c;

   rmez_acos_lane u_lane_alpha (.clock(clock), .en(en), .n_in(na_ff), .d_in(da_ff),
                                .angle(ang_a));
   rmez_acos_lane u_lane_beta  (.clock(clock), .en(en), .n_in(nb_ff), .d_in(db_ff),
                                .angle(ang_b));
   rmez_acos_lane u_lane_gamma (.clock(clock), .en(en), .n_in(nc_ff), .d_in(dc_ff),
                                .angle(ang_c));

   // Output register: mirroring to the full turn (a zero angle wraps to
   // zero) and zeroing of beta and gamma on the gimbal branch.
   rmez_side_type         side_o;
   logic [ANGLE_BITS-1:0] alpha_ff, beta_ff, gamma_ff;
   logic                  gimbal_ff;

   assign side_o = side_ff[LANE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= side_o.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         alpha_ff  <= side_o.mir_a ? -ang_a : ang_a;
         beta_ff   <= side_o.gimbal ? '0 : ang_b;
         gamma_ff  <= side_o.gimbal ? '0 : (side_o.mir_g ? -ang_c : ang_c);
         gimbal_ff <= side_o.gimbal;
      end
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.alpha_angle = alpha_ff;
   assign rsp.beta_angle  = beta_ff;
   assign rsp.gamma_angle = gamma_ff;
   assign rsp.gimbal_case = gimbal_ff;

   // The gimbal branch never reports a middle or third angle.
   `RMEZ_ASSERT_IMPLY(a_gimbal_zero, clock, reset, rsp_vld_ff && gimbal_ff,
      beta_ff == '0 && gamma_ff == '0)
   // Beta is an arccosine and never exceeds a half turn.
   `RMEZ_ASSERT_IMPLY(a_beta_range, clock, reset, rsp_vld_ff,
      beta_ff <= ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1)))
   // A held pipeline keeps its last stage, so the next response is not lost.
   `RMEZ_ASSERT_NEXT(a_hold_side, clock, reset, !en, $stable(side_o) && $stable(alpha_ff))
endmodule
`default_nettype wire

// ===== src/rmez_acos_lane.sv =====
`default_nettype none
// acos(n / sqrt(d)) as atan2(isqrt(d - n*n), n): square, radicand,
// one square-root digit per stage, then one CORDIC rotation per stage.
module rmez_acos_lane import rmez_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic signed [ELEM_W:0]       n_in,
   input  wire logic signed [31:0]           d_in,
   output logic         [ANGLE_BITS-1:0]     angle
);
   // Square stage.
   logic signed [ELEM_W:0] n_a_ff;
   logic signed [31:0]     d_a_ff;
   logic        [30:0]     n2_a_ff;
   logic        [33:0]     n2_full;

   assign n2_full = 34'(n_in * n_in);

   always_ff @(posedge clock) begin
      if (en) begin
         n_a_ff  <= n_in;
         d_a_ff  <= d_in;
         n2_a_ff <= n2_full[30:0];
      end
   end

   // Radicand stage.
   rmez_flags_type         fl_in;
   logic [32:0]            rad_full;
   rmez_flags_type         fl_ff  [0:SQRT_STEPS];
   logic signed [ELEM_W:0] n_ff   [0:SQRT_STEPS];
   logic [SQRT_W-1:0]      rem_ff [0:SQRT_STEPS];
   logic [SQRT_W-1:0]      res_ff [0:SQRT_STEPS];

   always_comb begin
      fl_in.dpos = d_a_ff > 32'sd0;
      fl_in.big  = $signed({2'b00, n2_a_ff}) >= 33'(d_a_ff);
      fl_in.npos = n_a_ff > 17'sd0;
      rad_full   = 33'(d_a_ff) - {2'b00, n2_a_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0]  <= fl_in;
         n_ff[0]   <= n_a_ff;
         rem_ff[0] <= SQRT_W'(rad_full[RAD_W-1:0]);
         res_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SQRT_W-1:0] BIT = SQRT_W'(64'd1 << (2 * (SQRT_STEPS - 1 - k)));
      logic [SQRT_W-1:0] trial;
      assign trial = res_ff[k] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            fl_ff[k+1] <= fl_ff[k];
            n_ff[k+1]  <= n_ff[k];
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1] <= rem_ff[k] - trial;
               res_ff[k+1] <= (res_ff[k] >> 1) + BIT;
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               res_ff[k+1] <= res_ff[k] >> 1;
            end
         end
      end
   end

   // CORDIC vectoring.
   logic signed [CORDIC_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_ff [0:CORDIC_STEPS];
   rmez_flags_type             cf_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] x0;
   logic signed [CORDIC_W-1:0] y0;

   assign x0 = CORDIC_W'(n_ff[SQRT_STEPS]) <<< GUARD_BITS;
   assign y0 = $signed(CORDIC_W'(res_ff[SQRT_STEPS])) <<< GUARD_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         cf_ff[0] <= fl_ff[SQRT_STEPS];
         if (x0 < 0) begin
            x_ff[0] <= y0;
            y_ff[0] <= -x0;
            z_ff[0] <= QUARTER_TURN;
         end else begin
            x_ff[0] <= x0;
            y_ff[0] <= y0;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [CORDIC_W-1:0] ATAN = CORDIC_W'(atan_entry(i));
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            cf_ff[i+1] <= cf_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end
         end
      end
   end

   // Clamp, special cases, rounding.
   logic [31:0]           zc;
   logic [32:0]           rnd;
   logic [ANGLE_BITS-1:0] angle_ff;
   rmez_flags_type        cf;
   logic signed [CORDIC_W-1:0] zl;

   assign cf = cf_ff[CORDIC_STEPS];
   assign zl = z_ff[CORDIC_STEPS];

   always_comb begin
      if (!cf.dpos) begin
         zc = '0;
      end else if (cf.big) begin
         zc = cf.npos ? 32'd0 : HALF_TURN;
      end else if (zl < 0) begin
         zc = '0;
      end else if (zl > $signed(CORDIC_W'(HALF_TURN))) begin
         zc = HALF_TURN;
      end else begin
         zc = zl[31:0];
      end
      rnd = {1'b0, zc} + ROUND_ADD;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= rnd[ANGLE_SH +: ANGLE_BITS];
      end
   end

   assign angle = angle_ff;
endmodule
`default_nettype wire

// ===== bench/euler_zxz_scoreboard.sv =====
`default_nettype none
package euler_zxz_scoreboard_pkg;
   import rmez_pkg::*;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } matrix_type;

   typedef struct packed {
      logic [15:0] alpha;
      logic [15:0] beta;
      logic [15:0] gamma;
      logic        gimbal;
   } angles_type;

   localparam longint HALF32 = 64'sd1 <<< 31;
   localparam longint QUART32 = 64'sd1 <<< 30;

   class euler_zxz_scoreboard;
      angles_type pending_angles[$];
      logic [28:0] threshold;
      int error_count;

      function new();
         threshold = THR_RESET;
         error_count = 0;
      endfunction

      // Floor square root, bit by bit.
      static function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // acos(n / sqrt(d)) in 2^-32 turn units, by vectoring CORDIC.
      static function longint arccos_turns(longint n, longint d);
         longint x, y, z, t, dx, dy;
         if (d <= 0) return 0;
         if (n * n >= d) return (n > 0) ? 0 : HALF32;
         y = longint'(floor_sqrt(d - n * n)) * 65536;
         x = n * 65536;
         z = 0;
         if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = QUART32;
         end
         for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx;
               y -= dy;
               z += longint'(atan_entry(i));
            end else begin
               x -= dx;
               y += dy;
               z -= longint'(atan_entry(i));
            end
         end
         if (z < 0) z = 0;
         if (z > HALF32) z = HALF32;
         return z;
      endfunction

      static function logic [15:0] round_angle(longint z);
         longint unsigned u;
         u = (longint'(z) + 32768) >> 16;
         return u[15:0];
      endfunction

      function void note_matrix(matrix_type m);
         angles_type a;
         longint one, d, mag;
         one = 64'sd1 <<< 28;
         d = one - longint'(m.m22) * longint'(m.m22);
         mag = (d < 0) ? -d : d;
         if (mag < longint'(threshold)) begin
            a.gimbal = 1'b1;
            a.beta = '0;
            a.gamma = '0;
            a.alpha = round_angle(arccos_turns(m.m00, one));
            if (m.m10 < 0) a.alpha = -a.alpha;
         end else begin
            a.gimbal = 1'b0;
            a.beta = round_angle(arccos_turns(m.m22, one));
            a.alpha = round_angle(arccos_turns(m.m21, d));
            if (m.m20 < 0) a.alpha = -a.alpha;
            a.gamma = round_angle(arccos_turns(-longint'(m.m12), d));
            if (m.m02 < 0) a.gamma = -a.gamma;
         end
         pending_angles.push_back(a);
      endfunction

      function void check_angles(angles_type got);
         angles_type exp_a;
         if (pending_angles.size() == 0) begin
            $error("unexpected response transaction");
            error_count++;
            return;
         end
         exp_a = pending_angles.pop_front();
         if (got.alpha !== exp_a.alpha) begin
            $error("alpha_angle expected %0d actual %0d", exp_a.alpha, got.alpha);
            error_count++;
         end
         if (got.beta !== exp_a.beta) begin
            $error("beta_angle expected %0d actual %0d", exp_a.beta, got.beta);
            error_count++;
         end
         if (got.gamma !== exp_a.gamma) begin
            $error("gamma_angle expected %0d actual %0d", exp_a.gamma, got.gamma);
            error_count++;
         end
         if (got.gimbal !== exp_a.gimbal) begin
            $error("gimbal_case expected %0d actual %0d", exp_a.gimbal, got.gimbal);
            error_count++;
         end
      endfunction
   endclass
endpackage
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
// Drives rotation matrices into the ZXZ Euler-angle pipeline and checks each
// response transaction against a scoreboard that predicts the angles.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rmez_pkg::*;
   import euler_zxz_scoreboard_pkg::*;

   localparam int LATENCY = 54;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   rmez_req_if req();
   rmez_rsp_if rsp();

   euler_zxz_scoreboard board = new();
   longint cycle_count = 0;
   bit stall_long = 0;     // the receiver holds off for a long stretch

   always #2 clock = ~clock;

   rotation_matrix_to_euler_zxz dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   initial begin
      req.valid = 1'b0;
      {req.m00, req.m02, req.m10, req.m12, req.m20, req.m21, req.m22} = '0;
      rsp.ready = 1'b0;
   end

   function automatic bit reset_done();
      return !reset;
   endfunction

   // Writes the threshold register through a setup and an access cycle.
   task automatic write_threshold(input logic [28:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.threshold = value;
   endtask

   // Offers one matrix and holds it until the transaction completes. Valid
   // stays high afterwards so that back-to-back transactions need no gap.
   task automatic send_matrix(input matrix_type m, input int gap);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      {req.m00, req.m02, req.m10, req.m12, req.m20, req.m21, req.m22} <= m;
      do @(posedge clock); while (!req.ready);
      board.note_matrix(m);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (board.pending_angles.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic signed [15:0] any_element();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 16'(-16384);
      if (sel == 1) return 16'sd16384;
      if (sel == 2) return 16'($urandom);   // outside the unit range too
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // Builds a matrix; some come from real rotations so the branches mix well.
   function automatic matrix_type random_matrix();
      matrix_type m;
      real a, b, g;
      m.m00 = any_element(); m.m02 = any_element(); m.m10 = any_element();
      m.m12 = any_element(); m.m20 = any_element(); m.m21 = any_element();
      m.m22 = any_element();
      case ($urandom_range(0, 3))
         0: begin
            a = $urandom_range(0, 6283) / 1000.0;
            b = $urandom_range(0, 3141) / 1000.0;
            g = $urandom_range(0, 6283) / 1000.0;
            m.m00 = 16'($rtoi(16384.0 * ($cos(a) * $cos(g) - $sin(a) * $cos(b) * $sin(g))));
            m.m10 = 16'($rtoi(16384.0 * ($sin(a) * $cos(g) + $cos(a) * $cos(b) * $sin(g))));
            m.m02 = 16'($rtoi(16384.0 * $sin(a) * $sin(b)));
            m.m12 = 16'($rtoi(-16384.0 * $cos(a) * $sin(b)));
            m.m20 = 16'($rtoi(16384.0 * $sin(b) * $sin(g)));
            m.m21 = 16'($rtoi(16384.0 * $sin(b) * $cos(g)));
            m.m22 = 16'($rtoi(16384.0 * $cos(b)));
         end
         1: m.m22 = ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                    + 16'($signed($urandom_range(0, 80)) - 40);
         default: ;
      endcase
      return m;
   endfunction

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      angles_type got;
      int wait_cycles;
      @(negedge clock);
      while (!reset_done()) @(negedge clock);
      forever begin
         if (stall_long) begin
            rsp.ready <= 1'b0;
            repeat (300) @(negedge clock);
            stall_long = 0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if ($urandom_range(0, 4) == 0) wait_cycles = 0;
         if (wait_cycles > 0) begin
            rsp.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         if (rsp.valid) begin
            got = '{rsp.alpha_angle, rsp.beta_angle, rsp.gamma_angle, rsp.gimbal_case};
            board.check_angles(got);
         end
         @(negedge clock);
      end
   end

   // Cycle watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      matrix_type m;
      logic [28:0] settings[4];
      settings = '{29'd0, 29'd268435456, 29'd5000000, THR_RESET};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners with the reset threshold: identity, flips, gimbal
      // at both poles, elements beyond one, and degenerate sines.
      send_matrix('{16384, 0, 0, 0, 0, 0, 16384}, 0);
      send_matrix('{-16384, 0, -5000, 0, 0, 0, -16384}, 0);
      send_matrix('{0, 0, 16384, 0, 0, 0, 16384}, 0);
      send_matrix('{0, -16384, 0, 16384, -16384, 0, 0}, 0);
      send_matrix('{0, 16384, 0, -16384, 16384, 16384, 0}, 1);
      send_matrix('{-32768, 0, 0, 0, 0, 0, 32767}, 0);
      send_matrix('{32767, -32768, -32768, -32768, -32768, -32768, -32768}, 0);
      send_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 20000}, 0);
      send_matrix('{0, -1, -1, 16383, -1, -16383, 100}, 0);
      send_matrix('{0, 0, 0, 0, 0, 0, 16380}, 0);
      send_matrix('{8192, 8192, -8192, -8192, -8192, 8192, 11585}, 2);
      wait_drained();

      // Zero threshold: exact poles leave D at zero on the normal branch.
      write_threshold(29'd0);
      send_matrix('{0, 5, -5, 5, -5, 5, 16384}, 0);
      send_matrix('{0, -5, 5, -5, 5, -5, -16384}, 0);
      send_matrix('{100, 100, 100, 100, 100, 100, 16390}, 0);

      for (int k = 0; k < 1200; k++) begin
         if (k % 300 == 0) begin
            wait_drained();
            write_threshold(settings[k / 300]);
         end
         if (k == 150) stall_long = 1;   // back the pipeline up
         if (k == 700) wait_drained();   // sender pauses until empty
         m = random_matrix();
         send_matrix(m, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0);
      end
      wait_drained();

      if (board.error_count == 0 && board.pending_angles.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
